// ===== design/pstu_pkg.sv =====
package pstu_pkg;

	// Widths of the limit and of the sum
	localparam int LIMIT_BITS = 16;
	localparam int SUM_BITS = 28;

	// Primes that can serve as trial divisors fit in half the limit width
	localparam int HALF_BITS = (LIMIT_BITS + 1) / 2;
	localparam int SQ_BITS = 2 * HALF_BITS;

	// Primes below 2^HALF_BITS never number more than 2^(HALF_BITS-1)
	localparam int PTAB_ADDR_BITS = HALF_BITS - 1;
	localparam int PTAB_DEPTH = 1 << PTAB_ADDR_BITS;

	// Divider step counter
	localparam int STEP_BITS = $clog2(LIMIT_BITS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CAND,
		ST_TEST,
		ST_CHECK,
		ST_DIV,
		ST_PRIME,
		ST_NEXT,
		ST_FINISH
	} pstu_state_t;

	typedef struct packed {
		logic                  start;
		logic [LIMIT_BITS-1:0] dividend;
		logic [HALF_BITS-1:0]  divisor;
	} pstu_div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic rem_zero;
	} pstu_div_sts_t;

	typedef struct packed {
		logic                 we;
		logic [HALF_BITS-1:0] data;
	} pstu_ptab_wr_t;

endpackage

// ===== design/pstu_div.sv =====
module pstu_div (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pstu_pkg::pstu_div_req_t req,
	output pstu_pkg::pstu_div_sts_t sts
);

	logic                            busy_q;
	logic [pstu_pkg::STEP_BITS-1:0]  cnt_q;
	logic [pstu_pkg::LIMIT_BITS-1:0] dvd_q;
	logic [pstu_pkg::HALF_BITS-1:0]  dvs_q;
	logic [pstu_pkg::HALF_BITS-1:0]  rem_q;

	logic [pstu_pkg::HALF_BITS:0]    trial;
	logic [pstu_pkg::HALF_BITS:0]    diff;
	logic                            ge;
	logic [pstu_pkg::HALF_BITS-1:0]  rem_next;
	logic                            last;

	// Restoring remainder step: bring down one dividend bit
	always_comb begin
		trial    = {rem_q, dvd_q[pstu_pkg::LIMIT_BITS-1]};
		ge       = trial >= {1'b0, dvs_q};
		diff     = trial - {1'b0, dvs_q};
		rem_next = ge ? diff[pstu_pkg::HALF_BITS-1:0] : trial[pstu_pkg::HALF_BITS-1:0];
		last     = cnt_q == pstu_pkg::STEP_BITS'(pstu_pkg::LIMIT_BITS - 1);
	end

	assign sts.busy     = busy_q;
	assign sts.done     = busy_q && last;
	assign sts.rem_zero = rem_next == '0;

	// Track the running division
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (last) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q + pstu_pkg::STEP_BITS'(1);
		end
	end

	// Shift the dividend and update the partial remainder
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[pstu_pkg::LIMIT_BITS-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q) else $error("divider started while busy");
	a_done_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(sts.done && !req.start) |=> !busy_q) else $error("divider busy after done");
	a_cnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy_q) |-> cnt_q == '0) else $error("divider step count not cleared");

endmodule

// ===== design/pstu_ptab.sv =====
module pstu_ptab (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                clear,
	input  pstu_pkg::pstu_ptab_wr_t             wr,
	input  logic                                rd_en,
	input  logic [pstu_pkg::PTAB_ADDR_BITS-1:0] rd_addr,
	output logic [pstu_pkg::HALF_BITS-1:0]      rd_data,
	output logic [pstu_pkg::HALF_BITS-1:0]      count
);

	logic [pstu_pkg::HALF_BITS-1:0] mem [pstu_pkg::PTAB_DEPTH];
	logic [pstu_pkg::HALF_BITS-1:0] count_q;
	logic [pstu_pkg::HALF_BITS-1:0] rd_data_q;

	// Fill count: entries at or above it are stale
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (clear) begin
			count_q <= '0;
		end else if (wr.we) begin
			count_q <= count_q + pstu_pkg::HALF_BITS'(1);
		end
	end

	// Append at the fill count; read data is registered
	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[count_q[pstu_pkg::PTAB_ADDR_BITS-1:0]] <= wr.data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
	assign count   = count_q;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr.we |-> count_q < pstu_pkg::HALF_BITS'(pstu_pkg::PTAB_DEPTH))
		else $error("prime table overflow");
	a_read_filled: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> {1'b0, rd_addr} < count_q) else $error("read of unfilled entry");
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd_en && wr.we)) else $error("read and write in the same cycle");

endmodule

// ===== design/prime_sum_up_to_limit.sv =====
// Sums every prime from 2 up to and including limit_value and returns one word
// per input word. Candidates are walked upward; each is tested by dividing it
// by the primes already found below 2^HALF_BITS, which sit in a small on-chip
// table, stopping once the divisor squared exceeds the candidate. A trial is a
// table read, a square compare and a division with one remainder bit per cycle.
// A candidate that outlasts the table is prime. The bit-per-cycle remainder
// unit sets the run time. The table is emptied by a fill count, so no clearing
// pass is needed. One item is worked at a time; a new word is taken once the
// previous result sits in the output register.
module prime_sum_up_to_limit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [pstu_pkg::LIMIT_BITS-1:0] limit_value,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [pstu_pkg::SUM_BITS-1:0]   prime_sum
);

	pstu_pkg::pstu_state_t state_q, state_d;

	logic [pstu_pkg::LIMIT_BITS-1:0] limit_q;
	logic [pstu_pkg::LIMIT_BITS:0]   n_q;
	logic [pstu_pkg::HALF_BITS-1:0]  idx_q;
	logic [pstu_pkg::SUM_BITS-1:0]   sum_q;
	logic                            out_valid_q;
	logic [pstu_pkg::SUM_BITS-1:0]   prime_sum_q;

	pstu_pkg::pstu_div_req_t div_req;
	pstu_pkg::pstu_div_sts_t div_sts;
	pstu_pkg::pstu_ptab_wr_t ptab_wr;
	logic                    ptab_clear;
	logic                    ptab_rd_en;
	logic [pstu_pkg::HALF_BITS-1:0] ptab_rd_data;
	logic [pstu_pkg::HALF_BITS-1:0] ptab_count;

	logic                          accept;
	logic                          past_limit;
	logic                          table_done;
	logic [pstu_pkg::SQ_BITS-1:0]  sq;
	logic                          sq_gt_n;
	logic                          small_cand;
	logic                          out_free;

	pstu_ptab u_ptab (
		.clk     (clk),
		.arst_n  (arst_n),
		.clear   (ptab_clear),
		.wr      (ptab_wr),
		.rd_en   (ptab_rd_en),
		.rd_addr (idx_q[pstu_pkg::PTAB_ADDR_BITS-1:0]),
		.rd_data (ptab_rd_data),
		.count   (ptab_count)
	);

	pstu_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.sts    (div_sts)
	);

	// Decisions on the current candidate
	always_comb begin
		accept     = in_valid && in_ready;
		past_limit = n_q > {1'b0, limit_q};
		table_done = idx_q == ptab_count;
		sq         = pstu_pkg::SQ_BITS'(ptab_rd_data) * pstu_pkg::SQ_BITS'(ptab_rd_data);
		sq_gt_n    = {1'b0, sq} > (pstu_pkg::SQ_BITS + 1)'(n_q);
		small_cand = n_q[pstu_pkg::LIMIT_BITS:pstu_pkg::HALF_BITS] == '0;
		out_free   = !out_valid_q || out_ready;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			pstu_pkg::ST_IDLE: begin
				if (accept) state_d = pstu_pkg::ST_CAND;
			end
			pstu_pkg::ST_CAND: begin
				state_d = past_limit ? pstu_pkg::ST_FINISH : pstu_pkg::ST_TEST;
			end
			pstu_pkg::ST_TEST: begin
				state_d = table_done ? pstu_pkg::ST_PRIME : pstu_pkg::ST_CHECK;
			end
			pstu_pkg::ST_CHECK: begin
				state_d = sq_gt_n ? pstu_pkg::ST_PRIME : pstu_pkg::ST_DIV;
			end
			pstu_pkg::ST_DIV: begin
				if (div_sts.done) begin
					state_d = div_sts.rem_zero ? pstu_pkg::ST_NEXT : pstu_pkg::ST_TEST;
				end
			end
			pstu_pkg::ST_PRIME:  state_d = pstu_pkg::ST_NEXT;
			pstu_pkg::ST_NEXT:   state_d = pstu_pkg::ST_CAND;
			pstu_pkg::ST_FINISH: begin
				if (out_free) state_d = pstu_pkg::ST_IDLE;
			end
			default: state_d = pstu_pkg::ST_IDLE;
		endcase
	end

	// Control outputs per state; table read and write never share a cycle
	always_comb begin
		in_ready         = 1'b0;
		ptab_clear       = 1'b0;
		ptab_rd_en       = 1'b0;
		ptab_wr.we       = 1'b0;
		ptab_wr.data     = n_q[pstu_pkg::HALF_BITS-1:0];
		div_req.start    = 1'b0;
		div_req.dividend = n_q[pstu_pkg::LIMIT_BITS-1:0];
		div_req.divisor  = ptab_rd_data;
		case (state_q)
			pstu_pkg::ST_IDLE: begin
				in_ready   = 1'b1;
				ptab_clear = in_valid;
			end
			pstu_pkg::ST_TEST:  ptab_rd_en = !table_done;
			pstu_pkg::ST_CHECK: div_req.start = !sq_gt_n;
			pstu_pkg::ST_PRIME: ptab_wr.we = small_cand;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pstu_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == pstu_pkg::ST_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath: capture limit, walk candidates, accumulate, load result word
	always_ff @(posedge clk) begin
		case (state_q)
			pstu_pkg::ST_IDLE: begin
				limit_q <= limit_value;
				n_q     <= (pstu_pkg::LIMIT_BITS + 1)'(2);
				sum_q   <= '0;
			end
			pstu_pkg::ST_CAND: idx_q <= '0;
			pstu_pkg::ST_DIV: begin
				if (div_sts.done) idx_q <= idx_q + pstu_pkg::HALF_BITS'(1);
			end
			pstu_pkg::ST_PRIME: sum_q <= sum_q + pstu_pkg::SUM_BITS'(n_q);
			pstu_pkg::ST_NEXT:  n_q <= n_q + (pstu_pkg::LIMIT_BITS + 1)'(1);
			pstu_pkg::ST_FINISH: begin
				if (out_free) prime_sum_q <= sum_q;
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign prime_sum = prime_sum_q;

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == pstu_pkg::ST_CAND) else $error("accepted word not started");
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pstu_pkg::ST_DIV |-> div_sts.busy) else $error("waiting on idle divider");
	a_check_filled: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pstu_pkg::ST_CHECK |-> idx_q < ptab_count)
		else $error("trial past table fill");
	a_store_small: assert property (@(posedge clk) disable iff (!arst_n)
		ptab_wr.we |-> n_q < (pstu_pkg::LIMIT_BITS + 1)'(1 << pstu_pkg::HALF_BITS))
		else $error("stored prime too wide");

endmodule

// ===== tb/sv/prime_sum_checker.sv =====
`timescale 1ns / 1ps

module prime_sum_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  logic [pstu_pkg::LIMIT_BITS-1:0] limit_value,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  logic [pstu_pkg::SUM_BITS-1:0]   prime_sum,
	output int unsigned                     mismatch_count,
	output int unsigned                     sums_pending
);

	logic [pstu_pkg::SUM_BITS-1:0] expected_sums[$];

	// Add up every prime up to lim; trial division stops once d * d passes the candidate
	function automatic logic [pstu_pkg::SUM_BITS-1:0] sum_primes_upto(
		input logic [pstu_pkg::LIMIT_BITS-1:0] lim
	);
		longint unsigned total;
		longint unsigned cand;
		longint unsigned d;
		bit              no_divisor;
		total = 0;
		for (cand = 2; cand <= lim; cand++) begin
			no_divisor = 1'b1;
			for (d = 2; d * d <= cand; d++) begin
				if (cand % d == 0) begin
					no_divisor = 1'b0;
					break;
				end
			end
			if (no_divisor)
				total += cand;
		end
		return total[pstu_pkg::SUM_BITS-1:0];
	endfunction

	// Print one line per mismatch and count it
	task automatic report_mismatch(input string what);
		$display("[%0t] MISMATCH: %s", $realtime, what);
		mismatch_count++;
	endtask

	// Clear under reset; predict on each accepted limit word, compare on each sum word
	always @(posedge clk) begin
		logic [pstu_pkg::SUM_BITS-1:0] want;
		if (!arst_n) begin
			expected_sums.delete();
			mismatch_count = 0;
			sums_pending = 0;
		end else begin
			if (in_valid && in_ready)
				expected_sums.push_back(sum_primes_upto(limit_value));
			if (out_valid && out_ready) begin
				if (expected_sums.size() == 0) begin
					report_mismatch($sformatf("sum word %0d with no limit outstanding",
						prime_sum));
				end else begin
					want = expected_sums.pop_front();
					if (prime_sum !== want)
						report_mismatch($sformatf("prime_sum got %0d, want %0d",
							prime_sum, want));
				end
			end
			sums_pending = expected_sums.size();
		end
	end

endmodule

// ===== tb/sv/prime_sum_up_to_limit_tb.sv =====
`timescale 1ns / 1ps

module prime_sum_up_to_limit_tb;

	// The directed word at the top limit is the slowest, the random words stay small;
	// CYCLE_LIMIT leaves room above the slowest correct run
	localparam int unsigned CYCLE_LIMIT = 40_000_000;
	localparam int          RANDOM_PER_PHASE = 19;
	localparam int          DRAIN_CYCLES = 20;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            in_valid = 1'b0;
	logic                            in_ready;
	logic [pstu_pkg::LIMIT_BITS-1:0] limit_value = '0;
	logic                            out_valid;
	logic                            out_ready = 1'b0;
	logic [pstu_pkg::SUM_BITS-1:0]   prime_sum;

	int unsigned mismatch_count;
	int unsigned sums_pending;
	int unsigned cycle_count = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;

	prime_sum_up_to_limit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.limit_value (limit_value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.prime_sum   (prime_sum)
	);

	prime_sum_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.limit_value    (limit_value),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.prime_sum      (prime_sum),
		.mismatch_count (mismatch_count),
		.sums_pending   (sums_pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Stall the result side at the current rate
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("prime_sum_up_to_limit_tb failed");
			$finish;
		end
	end

	// Idle at random, then hold the word until it is taken
	task automatic send_limit(input logic [pstu_pkg::LIMIT_BITS-1:0] lim);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		limit_value <= lim;
		do @(posedge clk); while (!in_ready);
	endtask

	// Mostly tiny limits, now and then a few thousand
	function automatic logic [pstu_pkg::LIMIT_BITS-1:0] pick_limit();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 90)
			return pstu_pkg::LIMIT_BITS'($urandom_range(255));
		else if (roll < 98)
			return pstu_pkg::LIMIT_BITS'($urandom_range(2047, 256));
		else
			return pstu_pkg::LIMIT_BITS'($urandom_range(8191, 2048));
	endfunction

	initial begin
		int unsigned directed[$];
		int unsigned phase;
		directed = '{0, 1, 2, 3, 4, 5, 6, 7, 10, 11, 12, 13, 24, 25, 49, 97, 100, 121,
			255, 256, 1000, 1024, 4096, 65535};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words with no idling: small limits, prime edges, all-ones limit
		foreach (directed[i])
			send_limit(pstu_pkg::LIMIT_BITS'(directed[i]));

		// Random words through each idling mix
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 59;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 59;
				end
				default: begin
					send_idle_pct = 33;
					recv_stall_pct = 33;
				end
			endcase
			repeat (RANDOM_PER_PHASE)
				send_limit(pick_limit());
		end
		in_valid <= 1'b0;

		// Drain outstanding sums
		@(posedge clk);
		while (sums_pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && sums_pending == 0)
			$display("prime_sum_up_to_limit_tb passed");
		else
			$display("prime_sum_up_to_limit_tb failed");
		$finish;
	end

endmodule

// ===== files.f =====
design/pstu_pkg.sv
design/pstu_div.sv
design/pstu_ptab.sv
design/prime_sum_up_to_limit.sv
tb/sv/prime_sum_checker.sv
tb/sv/prime_sum_up_to_limit_tb.sv
